@@ rtl/mt19937_range_draw_defines.svh @@
// assertion macros used by mt19937_range_draw
`ifndef MT19937_RANGE_DRAW_DEFINES_SVH
`define MT19937_RANGE_DRAW_DEFINES_SVH

// same-cycle implication
`define MTRD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtrd assertion failed");

// next-cycle implication
`define MTRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtrd assertion failed");

`endif

@@ rtl/mtrd_pkg.sv @@
`timescale 1ns / 1ps

package mtrd_pkg;

    localparam int unsigned STATE_WORDS  = 624;
    localparam int unsigned TWIST_OFFSET = 397;
    localparam int unsigned ADDR_W       = 10;

    localparam logic [31:0] MT_MATRIX    = 32'h9908B0DF;
    localparam logic [31:0] MT_UPPER     = 32'h80000000;
    localparam logic [31:0] MT_LOWER     = 32'h7FFFFFFF;
    localparam logic [31:0] MT_TEMPER_B  = 32'h9D2C5680;
    localparam logic [31:0] MT_TEMPER_C  = 32'hEFC60000;
    localparam logic [31:0] MT_INIT_MULT = 32'd1812433253;
    localparam logic [63:0] WIDE_LIMIT   = 64'h0000_0000_7FFF_FFFF;

    localparam logic [ADDR_W-1:0] LAST_IDX    = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W-1:0] EXHAUSTED   = ADDR_W'(STATE_WORDS);

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_WIDE  = 2'd2
    } draw_status_t;

    function automatic logic [31:0] temper(input logic [31:0] w_in);
        logic [31:0] w;
        w = w_in;
        w = w ^ (w >> 11);
        w = w ^ ((w << 7) & MT_TEMPER_B);
        w = w ^ ((w << 15) & MT_TEMPER_C);
        w = w ^ (w >> 18);
        return w;
    endfunction

endpackage

@@ rtl/mt19937_range_draw.sv @@
`timescale 1ns / 1ps
// MT19937 bounded draw. After reset or a seed write the 624-word table is
// filled from the seed, one word a cycle (no request taken). A request takes
// one tempered word and, if start < end and end-start < 0x7FFFFFFF, returns
// start + word mod (end-start+1), else 0 with status EMPTY or WIDE, via a
// status check, a table read and a restoring remainder loop, one bit a cycle.
// The first request after a fill and every 624th after it first regenerate
// the table in place through the two-read-port state memory. A new request
// is accepted while a finished result still waits at the output register.

`include "mt19937_range_draw_defines.svh"

module mt19937_range_draw (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               seed_we,
    input  logic [31:0]        seed_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [63:0] range_start,
    input  logic signed [63:0] range_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] drawn_value,
    output logic [1:0]         draw_status
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CHECK, S_FETCH, S_LOAD0, S_LOAD0W,
        S_RREAD, S_RWRITE, S_TEMPER, S_DIV, S_ADD, S_DONE
    } state_t;

    localparam int AW = mtrd_pkg::ADDR_W;

    state_t state_reg, state_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] cursor_reg, cursor_next;
    logic [31:0] prev_reg, prev_next;
    logic [31:0] seed_reg, seed_next;
    logic signed [63:0] start_reg, start_next;
    logic signed [63:0] end_reg, end_next;
    logic [63:0] gap_reg, gap_next;
    logic empty_reg, empty_next;
    mtrd_pkg::draw_status_t status_reg, status_next;
    logic [31:0] quot_reg, quot_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] divisor_reg, divisor_next;
    logic [4:0] cnt_reg, cnt_next;
    logic signed [63:0] value_reg, value_next;
    logic out_valid_reg, out_valid_next;
    logic signed [63:0] drawn_reg, drawn_next;
    logic [1:0] dstat_reg, dstat_next;

    logic we;
    logic [AW-1:0] waddr, raddr_a, raddr_b;
    logic [31:0] wdata, rdata_a, rdata_b;

    logic [AW:0] b_sum;
    logic [AW-1:0] a_idx, b_idx;
    logic [31:0] mix, twist;
    logic [31:0] init_word;
    logic [31:0] trial;

    mtrd_ram #(
        .WIDTH (32),
        .DEPTH (mtrd_pkg::STATE_WORDS)
    ) u_state (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    assign a_idx = (k_reg == mtrd_pkg::LAST_IDX) ? '0 : k_reg + 1'b1;
    assign b_sum = {1'b0, k_reg} + (AW+1)'(mtrd_pkg::TWIST_OFFSET);
    assign b_idx = (b_sum >= (AW+1)'(mtrd_pkg::STATE_WORDS))
                 ? AW'(b_sum - (AW+1)'(mtrd_pkg::STATE_WORDS)) : b_sum[AW-1:0];

    assign mix   = (prev_reg & mtrd_pkg::MT_UPPER) | (rdata_a & mtrd_pkg::MT_LOWER);
    assign twist = rdata_b ^ (mix >> 1) ^ (rdata_a[0] ? mtrd_pkg::MT_MATRIX : 32'd0);
    assign init_word = (k_reg == '0) ? seed_reg
                     : 32'(mtrd_pkg::MT_INIT_MULT * (prev_reg ^ (prev_reg >> 30)))
                       + 32'(k_reg);
    assign trial = {rem_reg[30:0], quot_reg[31]};

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        cursor_next    = cursor_reg;
        prev_next      = prev_reg;
        seed_next      = seed_reg;
        start_next     = start_reg;
        end_next       = end_reg;
        gap_next       = gap_reg;
        empty_next     = empty_reg;
        status_next    = status_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        divisor_next   = divisor_reg;
        cnt_next       = cnt_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg;
        drawn_next     = drawn_reg;
        dstat_next     = dstat_reg;
        we      = 1'b0;
        waddr   = k_reg;
        wdata   = init_word;
        raddr_a = '0;
        raddr_b = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                we        = 1'b1;
                prev_next = init_word;
                if (k_reg == mtrd_pkg::LAST_IDX)
                begin
                    cursor_next = mtrd_pkg::EXHAUSTED;
                    state_next  = S_IDLE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    start_next = range_start;
                    end_next   = range_end;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                empty_next = (start_reg >= end_reg);
                gap_next   = 64'(end_reg - start_reg);
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                if (empty_reg)
                    status_next = mtrd_pkg::ST_EMPTY;
                else if (gap_reg >= mtrd_pkg::WIDE_LIMIT)
                    status_next = mtrd_pkg::ST_WIDE;
                else
                    status_next = mtrd_pkg::ST_OK;
                if (cursor_reg >= mtrd_pkg::EXHAUSTED)
                begin
                    state_next = S_LOAD0;
                end
                else
                begin
                    raddr_a    = cursor_reg;
                    state_next = S_TEMPER;
                end
            end
            S_LOAD0:
            begin
                raddr_a    = '0;
                state_next = S_LOAD0W;
            end
            S_LOAD0W:
            begin
                prev_next  = rdata_a;
                k_next     = '0;
                state_next = S_RREAD;
            end
            S_RREAD:
            begin
                raddr_a    = a_idx;
                raddr_b    = b_idx;
                state_next = S_RWRITE;
            end
            S_RWRITE:
            begin
                we        = 1'b1;
                wdata     = twist;
                prev_next = rdata_a;
                if (k_reg == mtrd_pkg::LAST_IDX)
                begin
                    cursor_next = '0;
                    state_next  = S_FETCH;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_RREAD;
                end
            end
            S_TEMPER:
            begin
                cursor_next  = cursor_reg + 1'b1;
                quot_next    = mtrd_pkg::temper(rdata_a);
                rem_next     = '0;
                divisor_next = gap_reg[31:0] + 32'd1;
                cnt_next     = '0;
                value_next   = '0;
                state_next   = (status_reg == mtrd_pkg::ST_OK) ? S_DIV : S_DONE;
            end
            S_DIV:
            begin
                rem_next  = (trial >= divisor_reg) ? trial - divisor_reg : trial;
                quot_next = {quot_reg[30:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == 5'd31)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                value_next = start_reg + $signed({32'd0, rem_reg});
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    drawn_next     = value_reg;
                    dstat_next     = status_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (seed_we)
        begin
            seed_next  = seed_wdata;
            k_next     = '0;
            state_next = S_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            k_reg         <= '0;
            cursor_reg    <= mtrd_pkg::EXHAUSTED;
            prev_reg      <= '0;
            seed_reg      <= 32'd5489;
            start_reg     <= '0;
            end_reg       <= '0;
            gap_reg       <= '0;
            empty_reg     <= 1'b0;
            status_reg    <= mtrd_pkg::ST_OK;
            quot_reg      <= '0;
            rem_reg       <= '0;
            divisor_reg   <= 32'd1;
            cnt_reg       <= '0;
            value_reg     <= '0;
            out_valid_reg <= 1'b0;
            drawn_reg     <= '0;
            dstat_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            cursor_reg    <= cursor_next;
            prev_reg      <= prev_next;
            seed_reg      <= seed_next;
            start_reg     <= start_next;
            end_reg       <= end_next;
            gap_reg       <= gap_next;
            empty_reg     <= empty_next;
            status_reg    <= status_next;
            quot_reg      <= quot_next;
            rem_reg       <= rem_next;
            divisor_reg   <= divisor_next;
            cnt_reg       <= cnt_next;
            value_reg     <= value_next;
            out_valid_reg <= out_valid_next;
            drawn_reg     <= drawn_next;
            dstat_reg     <= dstat_next;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign drawn_value = drawn_reg;
    assign draw_status = dstat_reg;

    `MTRD_ASSERT_NOW(a_fail_zero, out_valid && (draw_status != mtrd_pkg::ST_OK), drawn_value == '0)
    `MTRD_ASSERT_NOW(a_cursor_range, in_ready, cursor_reg <= mtrd_pkg::EXHAUSTED)
    `MTRD_ASSERT_NOW(a_rem_bound, state_reg == S_DIV, rem_reg < divisor_reg)
    `MTRD_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready && !seed_we, !in_ready)

endmodule

@@ rtl/mtrd_ram.sv @@
`timescale 1ns / 1ps

module mtrd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ bench/mt19937_range_draw_checker.sv @@
`timescale 1ns / 1ps

module mt19937_range_draw_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               seed_we,
    input  logic [31:0]        seed_wdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [63:0] range_start,
    input  logic signed [63:0] range_end,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [63:0] drawn_value,
    input  logic [1:0]         draw_status,
    output int                 pending_draws,
    output int                 mismatch_count
);

    typedef struct packed {
        logic [63:0]            value;
        mtrd_pkg::draw_status_t status;
    } draw_result_t;

    logic [31:0]  twist_table [mtrd_pkg::STATE_WORDS];
    int unsigned  read_pos;
    draw_result_t expected_draws [$];

    function automatic void load_seed(input logic [31:0] seed);
        logic [31:0] prev;
        twist_table[0] = seed;
        for (int k = 1; k < mtrd_pkg::STATE_WORDS; k++)
        begin
            prev = twist_table[k-1];
            twist_table[k] = mtrd_pkg::MT_INIT_MULT * (prev ^ (prev >> 30)) + 32'(k);
        end
        read_pos = mtrd_pkg::STATE_WORDS;
    endfunction

    function automatic void twist_all();
        logic [31:0] nxt;
        logic [31:0] mix;
        logic [31:0] val;
        for (int k = 0; k < mtrd_pkg::STATE_WORDS; k++)
        begin
            nxt = twist_table[(k + 1) % mtrd_pkg::STATE_WORDS];
            mix = (twist_table[k] & mtrd_pkg::MT_UPPER) | (nxt & mtrd_pkg::MT_LOWER);
            val = twist_table[(k + mtrd_pkg::TWIST_OFFSET) % mtrd_pkg::STATE_WORDS]
                  ^ (mix >> 1);
            if (nxt[0])
                val = val ^ mtrd_pkg::MT_MATRIX;
            twist_table[k] = val;
        end
        read_pos = 0;
    endfunction

    function automatic logic [31:0] take_word();
        logic [31:0] w;
        if (read_pos >= mtrd_pkg::STATE_WORDS)
            twist_all();
        w = twist_table[read_pos];
        read_pos++;
        w = w ^ (w >> 11);
        w = w ^ ((w << 7) & mtrd_pkg::MT_TEMPER_B);
        w = w ^ ((w << 15) & mtrd_pkg::MT_TEMPER_C);
        w = w ^ (w >> 18);
        return w;
    endfunction

    function automatic draw_result_t predict_draw(input logic signed [63:0] lo,
                                                  input logic signed [63:0] hi);
        draw_result_t r;
        logic [63:0]  word;
        logic [63:0]  span;
        word = {32'd0, take_word()};
        r.value = '0;
        if (lo >= hi)
            r.status = mtrd_pkg::ST_EMPTY;
        else
        begin
            span = hi - lo;
            if (span >= mtrd_pkg::WIDE_LIMIT)
                r.status = mtrd_pkg::ST_WIDE;
            else
            begin
                r.status = mtrd_pkg::ST_OK;
                r.value = lo + (word % (span + 64'd1));
            end
        end
        return r;
    endfunction

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    initial
    begin
        mismatch_count = 0;
        load_seed(32'd5489);
    end

    assign pending_draws = expected_draws.size();

    always @(posedge clk or negedge rst_n)
    begin
        draw_result_t exp_r;
        if (!rst_n)
        begin
            expected_draws.delete();
            load_seed(32'd5489);
        end
        else
        begin
            if (seed_we)
                load_seed(seed_wdata);
            if (in_valid && in_ready)
                expected_draws.push_back(predict_draw(range_start, range_end));
            if (out_valid && out_ready)
            begin
                if (expected_draws.size() == 0)
                    report("result with no request outstanding");
                else
                begin
                    exp_r = expected_draws.pop_front();
                    if (draw_status !== exp_r.status)
                        report($sformatf("status %0d, expected %0d",
                                         draw_status, exp_r.status));
                    if (drawn_value !== exp_r.value)
                        report($sformatf("value %h, expected %h",
                                         drawn_value, exp_r.value));
                end
            end
        end
    end

endmodule

@@ bench/mt19937_range_draw_tb.sv @@
`timescale 1ns / 1ps

module mt19937_range_draw_tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 1400;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               seed_we = 1'b0;
    logic [31:0]        seed_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [63:0] range_start = '0;
    logic signed [63:0] range_end = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [63:0] drawn_value;
    logic [1:0]         draw_status;

    int pending_draws;
    int mismatch_count;
    int cycle_count = 0;
    int requests_sent = 0;
    bit hold_results = 1'b0;

    always #2 clk = ~clk;

    mt19937_range_draw u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed_we     (seed_we),
        .seed_wdata  (seed_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .range_start (range_start),
        .range_end   (range_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .drawn_value (drawn_value),
        .draw_status (draw_status)
    );

    mt19937_range_draw_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .seed_we        (seed_we),
        .seed_wdata     (seed_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .range_start    (range_start),
        .range_end      (range_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drawn_value    (drawn_value),
        .draw_status    (draw_status),
        .pending_draws  (pending_draws),
        .mismatch_count (mismatch_count)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)
            return 0;
        else if (r < 18)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 60);
    endfunction

    // result side: random stalls, calm stretches and one long hold
    always @(posedge clk)
    begin
        static int idle_left = 0;
        static int hold_left = 0;
        static int calm_left = 0;
        if (hold_results)
        begin
            hold_results = 1'b0;
            hold_left = 600;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (idle_left > 0)
        begin
            idle_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 30) == 0)
                calm_left = $urandom_range(50, 200);
            else if ($urandom_range(0, 2) == 0)
                idle_left = pick_gap();
        end
    end

    task automatic send_draw(input logic [63:0] lo, input logic [63:0] hi);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        range_start <= lo;
        range_end   <= hi;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        requests_sent++;
        if (requests_sent == 120)
            hold_results = 1'b1;
    endtask

    task automatic send_random_draw();
        logic [63:0] lo;
        logic [63:0] hi;
        lo = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: hi = lo + 64'($urandom_range(1, 1000));
            4, 5:       hi = lo + 64'($urandom & 32'h7FFF_FFFF);
            6:          hi = lo + 64'($urandom_range(32'h7FFF_FFFC, 32'h8000_0001));
            7:          hi = lo - 64'($urandom_range(0, 100));
            default:    hi = {$urandom, $urandom};
        endcase
        send_draw(lo, hi);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_draws != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        seed_we    <= 1'b1;
        seed_wdata <= seed;
        @(posedge clk);
        seed_we    <= 1'b0;
    endtask

    localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, empty and wide intervals, boundary spans
        send_draw(64'd0, 64'd1);
        send_draw(64'd5, 64'd5);
        send_draw(64'd6, 64'd5);
        send_draw(MIN64, MAX64);
        send_draw(MAX64, MIN64);
        send_draw(MIN64, MIN64 + 64'd1);
        send_draw(MAX64 - 64'd1, MAX64);
        send_draw(MAX64 - 64'd10, MAX64);
        send_draw(MIN64, MIN64 + 64'h7FFF_FFFE);
        send_draw(MIN64, MIN64 + 64'h7FFF_FFFF);
        send_draw(64'd0, 64'h7FFF_FFFE);
        send_draw(64'd0, 64'h7FFF_FFFF);
        send_draw(64'd0, 64'h8000_0000);
        send_draw(-64'sd100, 64'sd100);
        send_draw(-64'sd1, 64'sd0);
        send_draw(64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF);
        send_draw(64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_7FFF_FFFE);
        send_draw(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        send_draw(64'h5555_5555_5555_5555, 64'h5555_5555_5555_6555);
        send_draw(64'd0, 64'd0);
        repeat (640) send_random_draw();
        wait_idle();

        write_seed(32'd0);
        send_draw(64'd0, 64'h7FFF_FFFE);
        repeat (70) send_random_draw();
        wait_idle();

        write_seed(32'hFFFF_FFFF);
        send_draw(64'd0, 64'h7FFF_FFFE);
        repeat (70) send_random_draw();
        wait_idle();

        write_seed($urandom);
        repeat (60) send_random_draw();
        wait_idle();

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
